### rtl/b64e_pkg.sv
// Shared types, constants and the character mapping of the Base64 encoder.
package b64e_pkg;

	// Depth of the group queue between front and back, and its pointer width.
	localparam int unsigned QDEPTH = 2;
	localparam int unsigned QPTR_W = (QDEPTH > 1) ? $clog2(QDEPTH) : 1;
	localparam int unsigned QCNT_W = $clog2(QDEPTH + 1);

	// Padding character '='.
	localparam logic [7:0] PAD_CHAR = 8'h3D;

	// Character positions within one group of four output characters.
	localparam logic [1:0] POS_FIRST  = 2'd0;
	localparam logic [1:0] POS_SECOND = 2'd1;
	localparam logic [1:0] POS_THIRD  = 2'd2;
	localparam logic [1:0] POS_LAST   = 2'd3;

	// Byte counts held in the front.
	localparam logic [1:0] HELD_NONE = 2'd0;
	localparam logic [1:0] HELD_ONE  = 2'd1;
	localparam logic [1:0] HELD_TWO  = 2'd2;

	// One closed group on its way from the front to the back.
	typedef struct packed {
		logic [23:0] group;   // first byte in bits 23..16
		logic [1:0]  nbytes;  // 1, 2 or 3 bytes present
		logic        last;    // group closes the message
	} grp_t;

	// Maps a 6-bit value to its character of the standard alphabet.
	function automatic logic [7:0] b64_char(input logic [5:0] v);
		logic [7:0] w;
		w = {2'b00, v};
		if (v < 6'd26) begin
			return 8'h41 + w;
		end else if (v < 6'd52) begin
			return 8'h61 + w - 8'd26;
		end else if (v < 6'd62) begin
			return 8'h30 + w - 8'd52;
		end else if (v == 6'd62) begin
			return 8'h2B;
		end else begin
			return 8'h2F;
		end
	endfunction

endpackage

### rtl/base64_encoder_top.sv
// A byte that closes a group passes the group queue, the group register of the back part
// and the output register before its first character shows. The character serializer in
// the back part sends one character per cycle while m_tready is high, four per group.
// Bytes that leave a group open are taken whenever the group queue has room.
// Reset (arst_n low, asynchronous) clears the held bytes, the queue and the output.
module base64_encoder_top (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       s_tvalid,
	output logic       s_tready,
	input  logic [7:0] s_tdata,   // [7:0] data_byte
	input  logic       s_tlast,   // last_byte
	output logic       m_tvalid,
	input  logic       m_tready,
	output logic [7:0] m_tdata,   // [7:0] code_char
	output logic       m_tlast    // end_of_message
);

	b64e_pkg::grp_t push_grp;
	b64e_pkg::grp_t head_grp;
	logic           push;
	logic           pop;
	logic           q_empty;
	logic           q_full;

	b64e_front u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (s_tvalid),
		.in_byte  (s_tdata),
		.in_last  (s_tlast),
		.q_full   (q_full),
		.in_ready (s_tready),
		.push     (push),
		.push_grp (push_grp)
	);

	b64e_fifo u_fifo (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (push),
		.push_grp (push_grp),
		.pop      (pop),
		.head_grp (head_grp),
		.empty    (q_empty),
		.full     (q_full)
	);

	b64e_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.head_grp  (head_grp),
		.q_empty   (q_empty),
		.pop       (pop),
		.out_valid (m_tvalid),
		.out_char  (m_tdata),
		.out_last  (m_tlast),
		.out_ready (m_tready)
	);

endmodule

### rtl/b64e_front.sv
// Front part: gathers input bytes into groups of three and queues closed groups.
module b64e_front (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             in_valid,
	input  logic [7:0]       in_byte,
	input  logic             in_last,
	input  logic             q_full,
	output logic             in_ready,
	output logic             push,
	output b64e_pkg::grp_t   push_grp
);

	logic [15:0] pending_bytes_q;
	logic [1:0]  pending_count_q;
	logic        accept;
	logic        closes;

	// A byte is taken whenever the queue has room for a possible group.
	assign in_ready = !q_full;
	assign accept   = in_valid && in_ready;
	assign closes   = in_last || (pending_count_q == b64e_pkg::HELD_TWO);
	assign push     = accept && closes;

	// Assemble the group from the held bytes and the new one.
	always_comb begin
		push_grp.last   = in_last;
		push_grp.nbytes = pending_count_q + 2'd1;
		case (pending_count_q)
			b64e_pkg::HELD_NONE: push_grp.group = {in_byte, 16'h0000};
			b64e_pkg::HELD_ONE:  push_grp.group = {pending_bytes_q[15:8], in_byte, 8'h00};
			default:             push_grp.group = {pending_bytes_q, in_byte};
		endcase
	end

	// Hold open-group bytes; clear once a group is closed.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pending_bytes_q <= 16'h0000;
			pending_count_q <= b64e_pkg::HELD_NONE;
		end else if (accept) begin
			if (closes) begin
				pending_bytes_q <= 16'h0000;
				pending_count_q <= b64e_pkg::HELD_NONE;
			end else begin
				if (pending_count_q == b64e_pkg::HELD_NONE) begin
					pending_bytes_q <= {in_byte, 8'h00};
				end else begin
					pending_bytes_q <= {pending_bytes_q[15:8], in_byte};
				end
				pending_count_q <= pending_count_q + 2'd1;
			end
		end
	end

endmodule

### rtl/b64e_fifo.sv
// Short queue of closed groups between the front and the back.
module b64e_fifo (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             push,
	input  b64e_pkg::grp_t   push_grp,
	input  logic             pop,
	output b64e_pkg::grp_t   head_grp,
	output logic             empty,
	output logic             full
);

	b64e_pkg::grp_t                    mem_q [b64e_pkg::QDEPTH];
	logic [b64e_pkg::QPTR_W-1:0]      wr_ptr_q;
	logic [b64e_pkg::QPTR_W-1:0]      rd_ptr_q;
	logic [b64e_pkg::QCNT_W-1:0]      count_q;
	logic                              do_push;
	logic                              do_pop;

	assign empty    = (count_q == '0);
	assign full     = (count_q == b64e_pkg::QCNT_W'(b64e_pkg::QDEPTH));
	assign do_push  = push && !full;
	assign do_pop   = pop && !empty;
	assign head_grp = mem_q[rd_ptr_q];

	// Advance a pointer with wrap at the queue depth.
	function automatic logic [b64e_pkg::QPTR_W-1:0] next_ptr(
		input logic [b64e_pkg::QPTR_W-1:0] p);
		if (p == b64e_pkg::QPTR_W'(b64e_pkg::QDEPTH - 1)) begin
			return '0;
		end else begin
			return p + 1'b1;
		end
	endfunction

	// Entry storage needs no reset.
	always_ff @(posedge clk) begin
		if (do_push) begin
			mem_q[wr_ptr_q] <= push_grp;
		end
	end

	// Pointers and fill count.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= next_ptr(wr_ptr_q);
			end
			if (do_pop) begin
				rd_ptr_q <= next_ptr(rd_ptr_q);
			end
			if (do_push && !do_pop) begin
				count_q <= count_q + 1'b1;
			end else if (do_pop && !do_push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

	// The front never offers a group the queue cannot take.
	a_no_push_full: assert property (@(posedge clk) disable iff (!arst_n)
		!(push && full)) else $error("group pushed into full queue");

	// The back never pops an empty queue.
	a_no_pop_empty: assert property (@(posedge clk) disable iff (!arst_n)
		!(pop && empty)) else $error("pop from empty queue");

	// A lone push grows the fill count by one.
	a_push_count: assert property (@(posedge clk) disable iff (!arst_n)
		(do_push && !do_pop) |=> (count_q == $past(count_q) + 1'b1))
		else $error("fill count did not follow push");

endmodule

### rtl/b64e_back.sv
// Back part: turns each queued group into four characters, one per cycle while out_ready drains the output.
module b64e_back (
	input  logic             clk,
	input  logic             arst_n,
	input  b64e_pkg::grp_t   head_grp,
	input  logic             q_empty,
	output logic             pop,
	output logic             out_valid,
	output logic [7:0]       out_char,
	output logic             out_last,
	input  logic             out_ready
);

	b64e_pkg::grp_t  grp_q;
	logic            busy_q;
	logic [1:0]      pos_q;
	logic            out_valid_q;
	logic [7:0]      out_char_q;
	logic            out_last_q;
	logic            out_adv;
	logic            emit;
	logic            emit_last;
	logic [5:0]      sextet;
	logic [7:0]      next_char;

	// The output register can take a character when empty or being drained.
	assign out_adv   = !out_valid_q || out_ready;
	assign emit      = busy_q && out_adv;
	assign emit_last = emit && (pos_q == b64e_pkg::POS_LAST);
	assign pop       = !q_empty && (!busy_q || emit_last);

	// Pick the current sextet and apply padding for short groups.
	always_comb begin
		case (pos_q)
			b64e_pkg::POS_FIRST:  sextet = grp_q.group[23:18];
			b64e_pkg::POS_SECOND: sextet = grp_q.group[17:12];
			b64e_pkg::POS_THIRD:  sextet = grp_q.group[11:6];
			default:              sextet = grp_q.group[5:0];
		endcase
		next_char = b64e_pkg::b64_char(sextet);
		if ((pos_q == b64e_pkg::POS_THIRD) && (grp_q.nbytes < 2'd2)) begin
			next_char = b64e_pkg::PAD_CHAR;
		end
		if ((pos_q == b64e_pkg::POS_LAST) && (grp_q.nbytes < 2'd3)) begin
			next_char = b64e_pkg::PAD_CHAR;
		end
	end

	// Group under work and character position.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			pos_q  <= b64e_pkg::POS_FIRST;
		end else if (pop) begin
			busy_q <= 1'b1;
			pos_q  <= b64e_pkg::POS_FIRST;
		end else if (emit) begin
			busy_q <= !emit_last;
			pos_q  <= pos_q + 2'd1;
		end
	end

	always_ff @(posedge clk) begin
		if (pop) begin
			grp_q <= head_grp;
		end
	end

	// Output register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (emit) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (emit) begin
			out_char_q <= next_char;
			out_last_q <= (pos_q == b64e_pkg::POS_LAST) && grp_q.last;
		end
	end

	assign out_valid = out_valid_q;
	assign out_char  = out_char_q;
	assign out_last  = out_last_q;

	// A new group is only loaded while idle or as the fourth character of the old one is emitted.
	a_pop_when_free: assert property (@(posedge clk) disable iff (!arst_n)
		pop |-> (!busy_q || emit_last)) else $error("group loaded while busy");

	// A position past the first means a group is under work.
	a_pos_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(pos_q != b64e_pkg::POS_FIRST) |-> busy_q) else $error("position without group");

endmodule
